// File: hw/rtl/hud_pkg.sv
package hud_pkg;

	// H4 packet type bytes
	localparam logic [7:0] TYPE_CMD = 8'h01;
	localparam logic [7:0] TYPE_ACL = 8'h02;
	localparam logic [7:0] TYPE_SCO = 8'h03;

	// header bytes following the type byte, per packet kind
	localparam logic [2:0] CMD_HDR_LEN = 3'd3;
	localparam logic [2:0] ACL_HDR_LEN = 3'd4;
	// header position of the ACL length low byte
	localparam logic [2:0] LEN_LOW_POS = 3'd3;

	// result status codes
	localparam logic [2:0] ST_BUSY     = 3'd0;
	localparam logic [2:0] ST_DONE     = 3'd1;
	localparam logic [2:0] ST_BADTYPE  = 3'd2;
	localparam logic [2:0] ST_OVERFLOW = 3'd3;
	localparam logic [2:0] ST_TRUNC    = 3'd4;
	localparam logic [2:0] ST_HDRTO    = 3'd5;

	localparam int unsigned LEN_W = 17;
	localparam logic [LEN_W-1:0] LIMIT_RESET = 17'd512;
	localparam int unsigned HEADER_RETRIES_DEF = 3;

	// one input beat
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       is_timeout;
	} hud_item_t;

	// one result beat
	typedef struct packed {
		logic [7:0]       out_byte;
		logic             out_valid;
		logic             last;
		logic [2:0]       status;
		logic [LEN_W-1:0] packet_length;
	} hud_result_t;

endpackage

// File: hw/rtl/hud_frame_ctl.sv
module hud_frame_ctl import hud_pkg::*; #(
	parameter int unsigned HEADER_RETRIES = HEADER_RETRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  hud_item_t        item,
	input  logic [LEN_W-1:0] limit,
	output hud_result_t      res
);

	localparam int unsigned IDLE_W = $clog2(HEADER_RETRIES + 1);

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_HEADER  = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;

	logic [1:0]        phase_q,    phase_d;
	logic [1:0]        kind_q,     kind_d;
	logic [2:0]        hdr_cnt_q,  hdr_cnt_d;
	logic [7:0]        len_low_q,  len_low_d;
	logic [15:0]       pay_left_q, pay_left_d;
	logic [LEN_W-1:0]  count_q,    count_d;
	logic [IDLE_W-1:0] idle_to_q,  idle_to_d;

	logic [2:0]        hdr_inc;
	logic [2:0]        need;
	logic [LEN_W-1:0]  cnt_inc;
	logic [IDLE_W-1:0] idle_inc;
	logic [15:0]       pay_len;
	logic [LEN_W:0]    total;
	logic [7:0]        b;
	logic              tmo;

	assign b        = item.rx_byte;
	assign tmo      = item.is_timeout;
	assign hdr_inc  = hdr_cnt_q + 3'd1;
	assign cnt_inc  = count_q + LEN_W'(1);
	assign idle_inc = idle_to_q + IDLE_W'(1);
	assign need     = (kind_q == TYPE_ACL[1:0]) ? ACL_HDR_LEN : CMD_HDR_LEN;
	assign pay_len  = (kind_q == TYPE_ACL[1:0]) ? {b, len_low_q} : {8'h00, b};
	assign total    = {1'b0, cnt_inc} + {2'b00, pay_len[15:0]};

	// framing decision and next state for the beat in the input register
	always_comb begin
		phase_d    = phase_q;
		kind_d     = kind_q;
		hdr_cnt_d  = hdr_cnt_q;
		len_low_d  = len_low_q;
		pay_left_d = pay_left_q;
		count_d    = count_q;
		idle_to_d  = idle_to_q;

		res.out_byte      = tmo ? 8'h00 : b;
		res.out_valid     = 1'b0;
		res.last          = 1'b0;
		res.status        = ST_BUSY;
		res.packet_length = '0;

		if (phase_q != PH_HEADER && phase_q != PH_PAYLOAD) begin
			// waiting for a type byte (unused phase code acts the same)
			if (tmo) begin
				if (idle_inc >= IDLE_W'(HEADER_RETRIES)) begin
					res.status = ST_HDRTO;
					idle_to_d  = '0;
				end else begin
					idle_to_d = idle_inc;
				end
			end else begin
				phase_d    = PH_IDLE;
				kind_d     = '0;
				hdr_cnt_d  = '0;
				len_low_d  = '0;
				pay_left_d = '0;
				count_d    = '0;
				idle_to_d  = '0;
				if (b == TYPE_CMD || b == TYPE_ACL || b == TYPE_SCO) begin
					phase_d       = PH_HEADER;
					kind_d        = b[1:0];
					count_d       = LEN_W'(1);
					res.out_valid = 1'b1;
				end else begin
					res.status = ST_BADTYPE;
				end
			end
		end else if (tmo) begin
			// link went quiet inside a packet
			res.status        = ST_TRUNC;
			res.packet_length = count_q;
			phase_d    = PH_IDLE;
			kind_d     = '0;
			hdr_cnt_d  = '0;
			len_low_d  = '0;
			pay_left_d = '0;
			count_d    = '0;
			idle_to_d  = '0;
		end else if (phase_q == PH_HEADER) begin
			hdr_cnt_d     = hdr_inc;
			count_d       = cnt_inc;
			res.out_valid = 1'b1;
			if (hdr_inc >= need) begin
				// length complete: check against the limit
				if (total > {1'b0, limit}) begin
					res.out_valid     = 1'b0;
					res.status        = ST_OVERFLOW;
					res.packet_length = cnt_inc;
				end else if (pay_len == 16'd0) begin
					res.last          = 1'b1;
					res.status        = ST_DONE;
					res.packet_length = cnt_inc;
				end
				if (total > {1'b0, limit} || pay_len == 16'd0) begin
					phase_d    = PH_IDLE;
					kind_d     = '0;
					hdr_cnt_d  = '0;
					len_low_d  = '0;
					pay_left_d = '0;
					count_d    = '0;
					idle_to_d  = '0;
				end else begin
					phase_d    = PH_PAYLOAD;
					pay_left_d = pay_len;
				end
			end else if (hdr_inc == LEN_LOW_POS) begin
				len_low_d = b;
			end
		end else begin
			// payload byte
			res.out_valid = 1'b1;
			count_d       = cnt_inc;
			if (pay_left_q <= 16'd1) begin
				res.last          = 1'b1;
				res.status        = ST_DONE;
				res.packet_length = cnt_inc;
				phase_d    = PH_IDLE;
				kind_d     = '0;
				hdr_cnt_d  = '0;
				len_low_d  = '0;
				pay_left_d = '0;
				count_d    = '0;
				idle_to_d  = '0;
			end else begin
				pay_left_d = pay_left_q - 16'd1;
			end
		end
	end

	// framing state, updated as each beat moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			kind_q     <= '0;
			hdr_cnt_q  <= '0;
			len_low_q  <= '0;
			pay_left_q <= '0;
			count_q    <= '0;
			idle_to_q  <= '0;
		end else if (adv) begin
			phase_q    <= phase_d;
			kind_q     <= kind_d;
			hdr_cnt_q  <= hdr_cnt_d;
			len_low_q  <= len_low_d;
			pay_left_q <= pay_left_d;
			count_q    <= count_d;
			idle_to_q  <= idle_to_d;
		end
	end

endmodule

// File: hw/rtl/hci_uart_h4_deframer_unit.sv
// H4 deframer: splits a host byte stream into HCI UART H4 packets.
// Input channel rx_valid/rx_stall carries one beat per byte (rx_byte) or a
// receive timeout event (is_timeout high). Result channel res_valid/res_stall
// returns exactly one beat per input beat: the echoed byte, out_valid while
// the byte belongs to an accepted packet, last on the packet's final byte,
// a status code, and the byte count on done, overflow and truncation beats.
// cfg_wr_en/cfg_wr_data write packet_limit, the largest whole packet in
// bytes; write it only while no beat is in flight.
// An accepted beat sits in the input register; its result is loaded into the
// result register once that register is not held by a stall. Throughput is
// one beat per cycle while the result is not stalled: the framing state
// updates in a single pass between the two registers.
// A stalled result holds the result register; the input register keeps
// taking beats until it is full, then rx_stall rises.
// Reset clears both registers' valid flags, returns the framer to waiting
// for a type byte and sets packet_limit to 512.
module hci_uart_h4_deframer_unit import hud_pkg::*; #(
	parameter int unsigned HEADER_RETRIES = HEADER_RETRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rx_valid,
	output logic             rx_stall,
	input  logic [7:0]       rx_byte,
	input  logic             is_timeout,
	output logic             res_valid,
	input  logic             res_stall,
	output logic [7:0]       out_byte,
	output logic             out_valid,
	output logic             last,
	output logic [2:0]       status,
	output logic [LEN_W-1:0] packet_length,
	input  logic             cfg_wr_en,
	input  logic [LEN_W-1:0] cfg_wr_data
);

	logic             valid_s1;
	hud_item_t        item_s1;
	logic             valid_s2;
	hud_result_t      res_s2;
	hud_result_t      res_comb;
	logic [LEN_W-1:0] limit_q;
	logic             hold_s2;
	logic             adv;

	assign hold_s2  = valid_s2 && res_stall;
	assign adv      = valid_s1 && !hold_s2;
	assign rx_stall = valid_s1 && hold_s2;

	// packet limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			item_s1.rx_byte    <= rx_byte;
			item_s1.is_timeout <= is_timeout;
		end
	end

	hud_frame_ctl #(
		.HEADER_RETRIES(HEADER_RETRIES)
	) u_frame_ctl (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.item  (item_s1),
		.limit (limit_q),
		.res   (res_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!hold_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_comb;
		end
	end

	assign res_valid     = valid_s2;
	assign out_byte      = res_s2.out_byte;
	assign out_valid     = res_s2.out_valid;
	assign last          = res_s2.last;
	assign status        = res_s2.status;
	assign packet_length = res_s2.packet_length;

endmodule

// File: hw/rtl/hud_checker.sv
module hud_checker import hud_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             res_valid,
	input logic             res_stall,
	input logic [7:0]       out_byte,
	input logic             out_valid,
	input logic             last,
	input logic [2:0]       status,
	input logic [LEN_W-1:0] packet_length
);

	// last marks only a completed, accepted packet byte
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && last |-> out_valid && status == ST_DONE)
		else $error("last without done status");

	// no count on busy, bad type or header timeout beats
	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == ST_BUSY || status == ST_BADTYPE || status == ST_HDRTO)
		|-> packet_length == '0)
		else $error("packet_length set on non-reporting status");

	// error beats never carry a valid packet byte
	a_err_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == ST_BADTYPE || status == ST_OVERFLOW ||
		status == ST_TRUNC || status == ST_HDRTO) |-> !out_valid && !last)
		else $error("error beat marked valid");

	// stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(out_byte) &&
		$stable(status) && $stable(packet_length))
		else $error("stalled result changed");

endmodule

bind hci_uart_h4_deframer_unit hud_checker u_hud_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res_valid),
	.res_stall    (res_stall),
	.out_byte     (out_byte),
	.out_valid    (out_valid),
	.last         (last),
	.status       (status),
	.packet_length(packet_length)
);
